// ===== design/tdpt_pkg.sv =====
// tdpt_pkg: shared types and constants for the trial division prime test unit.
// Depends on nothing; imported by the sequencer top level.
`default_nettype none

package tdpt_pkg;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  localparam int unsigned SMALLEST_PRIME = 2;
  localparam int unsigned FIRST_DIVISOR  = 3;
  localparam int unsigned DIVISOR_STEP   = 2;

endpackage

`default_nettype wire

// ===== design/tdpt_div_unit.sv =====
// tdpt_div_unit: shared restoring divider, one quotient bit per cycle.
// Standalone; driven by the trial_division_prime_test_unit sequencer.
`default_nettype none

module tdpt_div_unit #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] dividend,
  input  wire logic [WIDTH-1:0] divisor,
  output logic                  done,
  output logic [WIDTH-1:0]      quotient,
  output logic [WIDTH-1:0]      remainder
);

  localparam int unsigned CW = $clog2(WIDTH + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] quo_r, quo_nxt;
  logic [WIDTH-1:0] div_r, div_nxt;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             fits;

  assign trial = {rem_r, quo_r[WIDTH-1]};
  assign diff  = trial - {1'b0, div_r};
  assign fits  = (trial >= {1'b0, div_r});

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    count_nxt = count_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    div_nxt   = div_r;
    if (start) begin
      busy_nxt  = 1'b1;
      count_nxt = CW'(WIDTH);
      rem_nxt   = '0;
      quo_nxt   = dividend;
      div_nxt   = divisor;
    end else if (busy_r) begin
      rem_nxt   = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      quo_nxt   = {quo_r[WIDTH-2:0], fits};
      count_nxt = count_r - CW'(1);
      if (count_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      count_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      count_r <= count_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// ===== design/trial_division_prime_test_unit.sv =====
// trial_division_prime_test_unit: trial division primality test, top level sequencer.
// Depends on tdpt_pkg and tdpt_div_unit.
//
//   channel | ports                          | direction
//   --------+--------------------------------+----------
//   in      | in_valid, in_ready, in_number  | to block
//   out     | out_valid, out_ready, out_is_prime | from block
//
// Negative, zero, one, two and even inputs pass through ST_CHECK and ST_FIN before
// out_valid rises, and in_ready returns at the same edge as out_valid.
// ST_FIN holds while an earlier result waits unaccepted. Odd inputs run one division
// per odd trial divisor on the shared one-bit-per-cycle divider.
// in_ready is high only while the sequencer is idle; a finished result waits in
// the output register, and the next transaction may be taken meanwhile.
// rst_n is synchronous, active low, and clears the sequencer and output valid.
`default_nettype none

module trial_division_prime_test_unit #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [DATA_WIDTH-1:0] in_number,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_is_prime
);

  import tdpt_pkg::*;

  localparam logic [DATA_WIDTH-1:0] TWO_W   = DATA_WIDTH'(SMALLEST_PRIME);
  localparam logic [DATA_WIDTH-1:0] FIRST_W = DATA_WIDTH'(FIRST_DIVISOR);
  localparam logic [DATA_WIDTH-1:0] STEP_W  = DATA_WIDTH'(DIVISOR_STEP);

  state_t                  state_r, state_nxt;
  logic [DATA_WIDTH-1:0]   n_r, n_nxt;
  logic [DATA_WIDTH-1:0]   d_r, d_nxt;
  logic                    res_r, res_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_prime_r, out_prime_nxt;
  logic                    div_start;
  logic                    div_done;
  logic [DATA_WIDTH-1:0]   div_quo;
  logic [DATA_WIDTH-1:0]   div_rem;

  tdpt_div_unit #(
    .WIDTH(DATA_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (n_r),
    .divisor  (d_nxt),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    res_nxt       = res_r;
    div_start     = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_prime_nxt = out_prime_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          n_nxt     = in_number;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (n_r[DATA_WIDTH-1] || (n_r < TWO_W)) begin
          res_nxt   = 1'b0;
          state_nxt = ST_FIN;
        end else if (n_r == TWO_W) begin
          res_nxt   = 1'b1;
          state_nxt = ST_FIN;
        end else if (!n_r[0]) begin
          res_nxt   = 1'b0;
          state_nxt = ST_FIN;
        end else begin
          d_nxt     = FIRST_W;
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (d_r > div_quo) begin
            res_nxt   = 1'b1;
            state_nxt = ST_FIN;
          end else if (div_rem == '0) begin
            res_nxt   = 1'b0;
            state_nxt = ST_FIN;
          end else begin
            d_nxt     = d_r + STEP_W;
            div_start = 1'b1;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r         <= n_nxt;
    d_r         <= d_nxt;
    res_r       <= res_nxt;
    out_prime_r <= out_prime_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_is_prime = out_prime_r;

`ifndef SYNTH
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_CHECK))
    else $error("accepted transaction did not enter the check state");

  a_odd_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> d_r[0])
    else $error("trial divisor is even");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result appeared without finishing a transaction");
`endif

endmodule

`default_nettype wire

// ===== bench/trial_division_prime_test_unit_tb.sv =====
// Testbench for trial_division_prime_test_unit: directed edge values, then random
// bursts of small, medium, negative, even and large composite numbers.
// Depends on tdpt_pkg and the block's RTL; checks every verdict against a local predictor.
`timescale 1ns / 1ps

module trial_division_prime_test_unit_tb;

  import tdpt_pkg::*;

  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned RANDOM_ITEMS = 75;

  class primality_scoreboard;
    logic signed [DATA_WIDTH-1:0] numbers[$];
    bit verdicts[$];
    int errors;
    int checked;
    int primes;

    function automatic bit predict_is_prime(logic signed [DATA_WIDTH-1:0] number);
      longint unsigned n;
      longint unsigned d;
      if (number <= 1) return 1'b0;
      n = longint'(number);
      if (n == SMALLEST_PRIME) return 1'b1;
      if (n[0] == 1'b0) return 1'b0;
      for (d = FIRST_DIVISOR; d * d <= n; d += DIVISOR_STEP) begin
        if (n % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_number(logic signed [DATA_WIDTH-1:0] number);
      numbers.push_back(number);
      verdicts.push_back(predict_is_prime(number));
    endfunction

    function void check_verdict(logic got);
      logic signed [DATA_WIDTH-1:0] number;
      bit want;
      if (verdicts.size() == 0) begin
        $error("is_prime: unexpected transaction, actual %0b", got);
        errors++;
        return;
      end
      number = numbers.pop_front();
      want = verdicts.pop_front();
      checked++;
      if (want) primes++;
      if (got !== want) begin
        $error("is_prime mismatch for %0d: expected %0b, actual %0b", number, want, got);
        errors++;
      end
    endfunction

    function int pending();
      return verdicts.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [DATA_WIDTH-1:0] in_number = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_is_prime;

  int stall_mode = 0;
  int stall_left = 0;
  int stall_phase = 0;
  int sent = 0;

  primality_scoreboard board = new();

  trial_division_prime_test_unit #(
    .DATA_WIDTH(DATA_WIDTH)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_number   (in_number),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_is_prime(out_is_prime)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver back-pressure: a new random mode is picked whenever the stall countdown runs out
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(50, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_phase <= stall_phase + 1;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (stall_phase % 8) < 5;
      default: out_ready <= (stall_phase % 32) >= 24;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) board.check_verdict(out_is_prime);
      if (in_valid && in_ready) board.note_number(in_number);
    end
  end

  task automatic send_number(logic signed [DATA_WIDTH-1:0] number);
    in_valid <= 1'b1;
    in_number <= number;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic idle_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  function automatic logic signed [DATA_WIDTH-1:0] pick_number();
    int sel;
    logic [DATA_WIDTH-1:0] raw;
    logic [DATA_WIDTH-1:0] odd;
    sel = $urandom_range(0, 99);
    raw = $urandom;
    odd = $urandom_range(0, 143165576) * 2 + 1;
    if (sel < 40) return $urandom_range(0, 4095);
    if (sel < 55) return {1'b1, raw[DATA_WIDTH-2:0]};
    if (sel < 70) return {raw[DATA_WIDTH-1:1], 1'b0};
    if (sel < 78) return odd * 3;
    if (sel < 86) return odd * 5;
    return $urandom_range(4096, 65535);
  endfunction

  initial begin
    logic signed [DATA_WIDTH-1:0] directed[$];
    int burst;
    int count;
    directed = '{
      32'sh8000_0000, -1, -2, 0, 1, 2, 3, 4, 5, 7, 9, 15, 25, 49, 97, 121,
      32'sh5555_5555, 32'shAAAA_AAAA, 32'sh3FFF_FFFF, 65521, 65535,
      2147483643, 2147483645, 2147483646, 2147483647
    };
    count = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send_number(directed[i]);
    end
    drain_results();

    while (count < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && count < RANDOM_ITEMS) begin
        send_number(pick_number());
        count++;
        burst--;
      end
      if (count == RANDOM_ITEMS / 2) drain_results();
      else if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 6));
    end

    drain_results();
    repeat (20) @(posedge clk);

    $display("Covered %0d transactions (%0d directed), %0d verdicts checked, %0d primes.",
             sent, directed.size(), board.checked, board.primes);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
design/tdpt_pkg.sv
design/tdpt_div_unit.sv
design/trial_division_prime_test_unit.sv
bench/trial_division_prime_test_unit_tb.sv
